// ===== design/contiguous_frame_allocator_macros.svh =====
// Assertion macros for the contiguous frame allocator.
// Included by the top level; uses its clk and rst_n signals.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cfa_pkg.sv =====
// Shared types, constants and helper functions of the contiguous frame allocator.
// Used by cfa_engine and contiguous_frame_allocator; depends on nothing.
package cfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 11;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ST_W       = 2;
    localparam int SUM_W      = FRAME_W + 1;

    localparam int IN_BITS     = FRAME_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = FRAME_W + STATUS_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_STAT_LSB = FRAME_W;
    localparam int OUT_FREE_LSB = FRAME_W + STATUS_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAME_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_MARK    = 2'd2,
        FUNC_INIT    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FIT   = 2'd1,
        STAT_OUTSIDE  = 2'd2,
        STAT_NOT_HEAD = 2'd3
    } status_t;

    // Per-frame state encodings.
    localparam logic [ST_W-1:0] FS_INACC = 2'd0;
    localparam logic [ST_W-1:0] FS_HEAD  = 2'd1;
    localparam logic [ST_W-1:0] FS_USED  = 2'd2;
    localparam logic [ST_W-1:0] FS_FREE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE      = 2'd2;

    localparam logic [FRAME_W-1:0] BASE_RESET  = '0;
    localparam logic [COUNT_W-1:0] TOTAL_RESET = 11'd1024;
    localparam logic               RESERVE_RESET = 1'b1;

    localparam logic [CNT_W-1:0] RESET_FREE =
        (MAX_FRAMES < 1024) ? CNT_W'(MAX_FRAMES) : CNT_W'(1024);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_FRAMES - 1);
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic [FRAME_W-1:0] base_frame;
        logic [COUNT_W-1:0] total_frames;
        logic               reserve_first;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] result_frame;
        status_t            status;
        logic [COUNT_W-1:0] free_count;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ST_W-1:0]  wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Pool size is the configured frame count clipped to the state memory depth.
    function automatic logic [CNT_W-1:0] pool_size(input logic [COUNT_W-1:0] total);
        if (32'(total) > MAX_FRAMES)
            return CNT_W'(MAX_FRAMES);
        else
            return CNT_W'(total);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] value);
        if (32'(value) > COUNT_MAX)
            return '1;
        else
            return COUNT_W'(value);
    endfunction

endpackage

// ===== design/cfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cfa_engine.sv =====
// Operation sequencer of the frame allocator: walks the frame state memory
// one entry per cycle. Depends on cfa_pkg; drives the state RAM in the top level.
module cfa_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfa_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cfa_pkg::func_t                in_func,
    input  logic [cfa_pkg::FRAME_W-1:0]   in_frame,
    input  logic [cfa_pkg::COUNT_W-1:0]   in_count,
    input  logic                          out_free,
    output cfa_pkg::res_t                 res,
    output cfa_pkg::mem_req_t             mem,
    input  logic [cfa_pkg::ST_W-1:0]      mem_rdata
);
    import cfa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_ALLOC_WR,
        S_REL_CHECK,
        S_REL_WALK,
        S_MARK_WR,
        S_INIT_WR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    status_t            status_reg, status_next;
    logic [FRAME_W-1:0] result_reg, result_next;

    logic [CNT_W-1:0]   pool_n;
    logic [CNT_W-1:0]   addr_inc;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   free_dec;
    logic [CNT_W-1:0]   free_inc;
    logic [FRAME_W-1:0] rel_off;
    logic               rel_in;
    logic [SUM_W-1:0]   mark_lo;
    logic [SUM_W-1:0]   mark_hi_req;
    logic [SUM_W-1:0]   mark_hi_pool;
    logic [SUM_W-1:0]   mark_hi;
    logic               mark_any;
    logic               rd_free;
    logic               found;

    assign pool_n   = pool_size(cfg.total_frames);
    assign addr_inc = addr_reg + 1'b1;
    assign run_inc  = run_reg + 1'b1;
    assign free_dec = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
    assign free_inc = (32'(free_reg) < MAX_FRAMES) ? free_reg + 1'b1 : free_reg;

    assign rel_off = frame_reg - cfg.base_frame;
    assign rel_in  = (frame_reg >= cfg.base_frame) && (32'(rel_off) < 32'(pool_n));

    // The mark range is clipped to the pool on both ends before the write sweep.
    assign mark_lo      = (frame_reg < cfg.base_frame) ? SUM_W'(cfg.base_frame)
                                                       : SUM_W'(frame_reg);
    assign mark_hi_req  = SUM_W'(frame_reg) + SUM_W'(count_reg);
    assign mark_hi_pool = SUM_W'(cfg.base_frame) + SUM_W'(pool_n);
    assign mark_hi      = (mark_hi_req > mark_hi_pool) ? mark_hi_pool : mark_hi_req;
    assign mark_any     = mark_hi > mark_lo;

    assign rd_free = (mem_rdata == FS_FREE);
    assign found   = rd_free && (32'(run_inc) == 32'(count_reg));

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        frame_next  = frame_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        start_next  = start_reg;
        run_next    = run_reg;
        free_next   = free_reg;
        status_next = status_reg;
        result_next = result_reg;

        mem.we    = 1'b0;
        mem.waddr = addr_reg[IDX_W-1:0];
        mem.wdata = FS_FREE;
        mem.raddr = addr_reg[IDX_W-1:0];

        in_ready         = (state_reg == S_IDLE);
        res.valid        = 1'b0;
        res.result_frame = result_reg;
        res.status       = status_reg;
        res.free_count   = sat_count(free_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem.we = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = in_func;
                    frame_next = in_frame;
                    count_next = in_count;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next = STAT_OK;
                result_next = '0;
                addr_next   = '0;
                case (func_reg)
                    FUNC_ALLOC:
                    begin
                        if (count_reg == '0 || 32'(count_reg) > 32'(free_reg)
                            || pool_n == '0)
                        begin
                            status_next = STAT_NO_FIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            run_next   = '0;
                            start_next = '0;
                            mem.raddr  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        if (!rel_in)
                        begin
                            status_next = STAT_OUTSIDE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            addr_next  = CNT_W'(rel_off);
                            mem.raddr  = rel_off[IDX_W-1:0];
                            state_next = S_REL_CHECK;
                        end
                    end
                    FUNC_MARK:
                    begin
                        if (mark_any)
                        begin
                            addr_next  = CNT_W'(mark_lo - SUM_W'(cfg.base_frame));
                            end_next   = CNT_W'(mark_hi - SUM_W'(cfg.base_frame));
                            state_next = S_MARK_WR;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_INIT:
                    begin
                        free_next  = (cfg.reserve_first && pool_n != '0) ? pool_n - 1'b1
                                                                         : pool_n;
                        state_next = S_INIT_WR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Linear first-fit scan: the read for addr_reg was issued last cycle.
            S_SCAN:
            begin
                if (found)
                begin
                    end_next   = addr_reg;
                    addr_next  = start_reg;
                    state_next = S_ALLOC_WR;
                end
                else
                begin
                    run_next = rd_free ? run_inc : '0;
                    if (!rd_free)
                    begin
                        start_next = addr_inc;
                    end
                    if (addr_inc == pool_n)
                    begin
                        status_next = STAT_NO_FIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        addr_next = addr_inc;
                        mem.raddr = addr_inc[IDX_W-1:0];
                    end
                end
            end

            S_ALLOC_WR:
            begin
                mem.we    = 1'b1;
                mem.wdata = (addr_reg == start_reg) ? FS_HEAD : FS_USED;
                free_next = free_dec;
                if (addr_reg == end_reg)
                begin
                    result_next = cfg.base_frame + FRAME_W'(start_reg);
                    state_next  = S_DONE;
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end

            S_REL_CHECK:
            begin
                if (mem_rdata != FS_HEAD)
                begin
                    status_next = STAT_NOT_HEAD;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem.we     = 1'b1;
                    free_next  = free_inc;
                    addr_next  = addr_inc;
                    mem.raddr  = addr_inc[IDX_W-1:0];
                    state_next = S_REL_WALK;
                end
            end

            // The write goes to addr_reg while the read fetches the entry after it,
            // so a read never meets a write to the same entry.
            S_REL_WALK:
            begin
                if (addr_reg < pool_n && mem_rdata == FS_USED)
                begin
                    mem.we    = 1'b1;
                    free_next = free_inc;
                    addr_next = addr_inc;
                    mem.raddr = addr_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_MARK_WR:
            begin
                mem.we    = 1'b1;
                mem.wdata = FS_INACC;
                addr_next = addr_inc;
                if (addr_inc == end_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_INIT_WR:
            begin
                mem.we    = 1'b1;
                mem.wdata = (addr_reg == '0 && cfg.reserve_first && pool_n != '0)
                            ? FS_HEAD : FS_FREE;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            free_reg  <= RESET_FREE;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        frame_reg  <= frame_next;
        count_reg  <= count_next;
        end_reg    <= end_next;
        start_reg  <= start_next;
        run_reg    <= run_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

endmodule

// ===== design/contiguous_frame_allocator.sv =====
// Top level of the contiguous frame allocator: ports, configuration registers,
// output register and the frame state RAM. Depends on cfa_pkg, cfa_ram, cfa_engine.
//
// Usage: one item on the s_ channel is one operation (tuser selects allocate,
// release, mark inaccessible or initialize); each item yields exactly one item
// on the m_ channel with the head frame, a status code and the free count.
// Configuration registers are written over cfg_valid/cfg_index/cfg_data,
// always ready; the user must write them only while no operation is in flight,
// as the block itself does not enforce it. Allocate scans the state RAM
// linearly, then writes once per frame of the run; release walks the run one
// frame per cycle; mark writes once per frame of the clipped range; initialize
// writes every entry of the state RAM once. The state RAM has a single write
// port; one item is worked on at a time.
// After reset the block runs a clearing pass that marks every frame free;
// s_tready stays low during it.
// A result waits in the output register while m_tready is low; the next item
// is accepted and worked on meanwhile, and its result is held until the slot frees.
`include "contiguous_frame_allocator_macros.svh"

module contiguous_frame_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [19:0] frame_number, [30:20] frame_count, [31] zero
    input  logic [cfa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] func
    input  logic [cfa_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [19:0] result_frame, [21:20] status, [32:22] free_count, [39:33] zero
    output logic [cfa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cfa_pkg::*;

    logic [FRAME_W-1:0]     base_reg;
    logic [COUNT_W-1:0]     total_reg;
    logic                   reserve_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    cfg_t                   cfg;
    res_t                   eng_res;
    mem_req_t               mem;
    logic [ST_W-1:0]        mem_rdata;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign cfg.base_frame    = base_reg;
    assign cfg.total_frames  = total_reg;
    assign cfg.reserve_first = reserve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= BASE_RESET;
            total_reg   <= TOTAL_RESET;
            reserve_reg <= RESERVE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_FRAME:   base_reg    <= cfg_data[FRAME_W-1:0];
                CFG_TOTAL_FRAMES: total_reg   <= cfg_data[COUNT_W-1:0];
                CFG_RESERVE:      reserve_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    cfa_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_frame  (s_tdata[FRAME_W-1:0]),
        .in_count  (s_tdata[FRAME_W +: COUNT_W]),
        .out_free  (out_free),
        .res       (eng_res),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    cfa_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_FRAMES)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (eng_res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res.valid)
        begin
            m_tdata_reg <= {{(OUT_TDATA_W - OUT_BITS){1'b0}}, eng_res.free_count,
                            eng_res.status, eng_res.result_frame};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CFA_ASSERT_IMP(a_result_slot_free, eng_res.valid, !m_tvalid_reg || m_tready, "result issued into a busy output register")
    `CFA_ASSERT_NXT(a_one_op_in_flight, s_tvalid && s_tready, !s_tready, "second item accepted while an operation runs")
    `CFA_ASSERT_IMP(a_fail_has_no_frame, m_tvalid_reg && m_tdata_reg[OUT_STAT_LSB +: STATUS_W] != STAT_OK, m_tdata_reg[FRAME_W-1:0] == '0, "failed operation reports a frame")
    `CFA_ASSERT_IMP(a_free_count_bound, m_tvalid_reg, 32'(m_tdata_reg[OUT_FREE_LSB +: COUNT_W]) <= MAX_FRAMES, "free count above pool capacity")

endmodule
